// File: hw/rtl/nsf_pkg.sv
// Package for the NMEA sentence framer: sizes, character codes, event kinds,
// the result word type and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nsf_pkg;

    // Sentence length limit and derived widths
    localparam int MAX_SENTENCE = 128;
    localparam int CNT_W        = $clog2(MAX_SENTENCE + 1);
    localparam int BYTE_W       = 8;
    localparam int OUT_W        = 7;

    // Character codes
    localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_R      = 8'h52;
    localparam logic [BYTE_W-1:0] CHAR_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] CHAR_C      = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_S      = 8'h53;
    localparam logic [BYTE_W-1:0] CHAR_V      = 8'h56;

    // Event kinds reported with each result word
    typedef enum logic [2:0] {
        KIND_IGNORED  = 3'd0,
        KIND_START    = 3'd1,
        KIND_STORED   = 3'd2,
        KIND_COMPLETE = 3'd3,
        KIND_BAD_CHAR = 3'd4,
        KIND_OVERFLOW = 3'd5
    } t_kind;

    // Sentence type codes
    typedef enum logic [1:0] {
        TYPE_OTHER = 2'd0,
        TYPE_RMC   = 2'd1,
        TYPE_GSV   = 2'd2
    } t_stype;

    // One result word
    typedef struct packed {
        t_kind             event_kind;
        logic [OUT_W-1:0]  byte_value;
        logic [OUT_W-1:0]  byte_index;
        logic [OUT_W-1:0]  sentence_length;
        logic              checksum_ok;
        t_stype            sentence_type;
    } t_result;

    // Decode one ASCII hex digit: bit 4 flags a valid digit
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/nsf_input_reg.sv
// Input stage of the NMEA sentence framer: holds one received byte word.
// Depends on nsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsf_input_reg (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [nsf_pkg::BYTE_W-1:0] i_byte,
    output logic                           o_valid,
    input  wire logic                      i_advance,
    output logic [nsf_pkg::BYTE_W-1:0]     o_byte
);
    import nsf_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // Take a word when empty or when the held one moves on
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold payload until replaced
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

// File: hw/rtl/nsf_framer.sv
// Sentence state and per-byte decision logic of the NMEA sentence framer.
// Depends on nsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsf_framer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire logic [nsf_pkg::BYTE_W-1:0] i_byte,
    output nsf_pkg::t_result                o_result
);
    import nsf_pkg::*;

    logic              r_in_sentence, n_in_sentence;
    logic [CNT_W-1:0]  r_count,       n_count;
    logic [BYTE_W-1:0] r_xor,         n_xor;
    logic [BYTE_W-1:0] r_tail [3];
    logic [BYTE_W-1:0] n_tail [3];
    logic [BYTE_W-1:0] r_type [3];
    logic [BYTE_W-1:0] n_type [3];

    logic [CNT_W-1:0]  count_inc;
    logic [1:0]        type_sel;
    logic [4:0]        hex_hi, hex_lo;
    logic [BYTE_W-1:0] body_xor;
    t_result           res;

    assign count_inc = r_count + CNT_W'(1);
    assign type_sel  = 2'(r_count - CNT_W'(2));
    assign hex_hi    = hex_digit(r_tail[1]);
    assign hex_lo    = hex_digit(r_tail[2]);
    // XOR of everything before the last three characters
    assign body_xor  = r_xor ^ r_tail[0] ^ r_tail[1] ^ r_tail[2];

    // Decide the event and next state for the current byte
    always_comb begin
        n_in_sentence = r_in_sentence;
        n_count       = r_count;
        n_xor         = r_xor;
        n_tail        = r_tail;
        n_type        = r_type;
        res           = '0;
        res.event_kind    = KIND_IGNORED;
        res.sentence_type = TYPE_OTHER;

        if (i_byte == CHAR_DOLLAR) begin
            // start or restart: clear the sentence
            n_in_sentence  = 1'b1;
            n_count        = '0;
            n_xor          = '0;
            n_tail         = '{default: '0};
            n_type         = '{default: '0};
            res.event_kind = KIND_START;
        end else if (!r_in_sentence) begin
            res.event_kind = KIND_IGNORED;
        end else if (i_byte == CHAR_CR) begin
            // end of sentence: report length, checksum and type
            n_in_sentence       = 1'b0;
            res.event_kind      = KIND_COMPLETE;
            res.sentence_length = OUT_W'(r_count);
            if (r_count >= CNT_W'(3) && hex_hi[4] && hex_lo[4]
                && body_xor == {hex_hi[3:0], hex_lo[3:0]}) begin
                res.checksum_ok = 1'b1;
            end
            if (r_count >= CNT_W'(5)) begin
                if (r_type[0] == CHAR_R && r_type[1] == CHAR_M && r_type[2] == CHAR_C) begin
                    res.sentence_type = TYPE_RMC;
                end else if (r_type[0] == CHAR_G && r_type[1] == CHAR_S
                             && r_type[2] == CHAR_V) begin
                    res.sentence_type = TYPE_GSV;
                end
            end
        end else if (i_byte == CHAR_LF || i_byte == CHAR_NUL || i_byte[BYTE_W-1]) begin
            // drop the sentence on a bad character
            n_in_sentence  = 1'b0;
            res.event_kind = KIND_BAD_CHAR;
        end else begin
            // store a payload byte
            res.byte_value = i_byte[OUT_W-1:0];
            res.byte_index = OUT_W'(r_count);
            n_xor          = r_xor ^ i_byte;
            n_tail[0]      = r_tail[1];
            n_tail[1]      = r_tail[2];
            n_tail[2]      = i_byte;
            if (r_count >= CNT_W'(2) && r_count <= CNT_W'(4)) begin
                n_type[type_sel] = i_byte;
            end
            n_count = count_inc;
            if (count_inc >= CNT_W'(MAX_SENTENCE)) begin
                n_in_sentence  = 1'b0;
                res.event_kind = KIND_OVERFLOW;
            end else begin
                res.event_kind = KIND_STORED;
            end
        end
    end

    // Advance sentence state when the word moves to the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence <= 1'b0;
            r_count       <= '0;
            r_xor         <= '0;
            r_tail        <= '{default: '0};
            r_type        <= '{default: '0};
        end else if (i_advance) begin
            r_in_sentence <= n_in_sentence;
            r_count       <= n_count;
            r_xor         <= n_xor;
            r_tail        <= n_tail;
            r_type        <= n_type;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

// File: hw/rtl/nsf_output_reg.sv
// Output stage of the NMEA sentence framer: holds one result word.
// Depends on nsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsf_output_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_free,
    input  wire nsf_pkg::t_result i_result,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output nsf_pkg::t_result      o_result
);
    import nsf_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Free when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    // Load a new result word
    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: hw/rtl/nmea_sentence_framer.sv
// Top level of the NMEA sentence framer: input stage, framer logic, output stage.
// Depends on nsf_pkg, nsf_input_reg, nsf_framer and nsf_output_reg.
//
//   channel  | valid       | ready        | payload
//   ---------+-------------+--------------+-------------------------------------
//   rx in    | i_rx_valid  | o_rx_ready   | i_rx_byte
//   event out| o_ev_valid  | i_ev_ready   | o_event_kind .. o_sentence_type
//
// One byte word per cycle unless the output stalls; a result is loaded into the
// output stage as its byte leaves the input stage. The nsf_framer state update
// sets the rate. A stalled output holds its word; an empty input stage takes one
// more byte. Synchronous active-low reset returns the framer to hunting for '$'.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_framer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rx_valid,
    output logic                            o_rx_ready,
    input  wire logic [nsf_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                            o_ev_valid,
    input  wire logic                       i_ev_ready,
    output logic [2:0]                      o_event_kind,
    output logic [nsf_pkg::OUT_W-1:0]       o_byte_value,
    output logic [nsf_pkg::OUT_W-1:0]       o_byte_index,
    output logic [nsf_pkg::OUT_W-1:0]       o_sentence_length,
    output logic                            o_checksum_ok,
    output logic [1:0]                      o_sentence_type
);
    import nsf_pkg::*;

    logic              stage_valid;
    logic              out_free;
    logic              advance;
    logic [BYTE_W-1:0] stage_byte;
    t_result           frame_result;
    t_result           out_result;

    // Move the held byte when the output stage can take its result
    assign advance = stage_valid && out_free;

    nsf_input_reg u_input (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx_valid),
        .o_ready   (o_rx_ready),
        .i_byte    (i_rx_byte),
        .o_valid   (stage_valid),
        .i_advance (advance),
        .o_byte    (stage_byte)
    );

    nsf_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (stage_byte),
        .o_result  (frame_result)
    );

    nsf_output_reg u_output (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid),
        .o_free   (out_free),
        .i_result (frame_result),
        .o_valid  (o_ev_valid),
        .i_ready  (i_ev_ready),
        .o_result (out_result)
    );

    // Unpack the result word onto the ports
    assign o_event_kind      = out_result.event_kind;
    assign o_byte_value      = out_result.byte_value;
    assign o_byte_index      = out_result.byte_index;
    assign o_sentence_length = out_result.sentence_length;
    assign o_checksum_ok     = out_result.checksum_ok;
    assign o_sentence_type   = out_result.sentence_type;

endmodule

`default_nettype wire
